// ----- rtl/shp3_pkg.sv -----
// ----------------------------------------------------------------------------
// shp3_pkg
// Shared constants, types and register codes of the 3x3 sharpening filter.
// ----------------------------------------------------------------------------
package shp3_pkg;

  localparam int MAX_WIDTH     = 2048;
  localparam int MAX_CHANNELS  = 4;
  localparam int MAX_HEIGHT    = 4096;
  localparam int STORE_DEPTH   = MAX_WIDTH * MAX_CHANNELS;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int CSEL_W        = $clog2(MAX_CHANNELS);
  localparam int KERNEL_CENTRE = 5;

  localparam int SAMPLE_W = 8;
  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 13;
  localparam int CHAN_W   = 3;
  localparam int ROW_W    = 12;
  localparam int IDX_W    = 13;
  localparam int LEN_W    = 14;
  localparam int SUM_W    = 12;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CREDIT_W    = QCNT_W + 1;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
  localparam logic [CHAN_W-1:0]   CHAN_RESET   = CHAN_W'(3);

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic [CHAN_W-1:0]   chans;
    logic [LEN_W-1:0]    len;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic [ROW_W-1:0]    row;
    logic [IDX_W-1:0]    idx;
    logic                last_row;
    logic                eof;
  } item_t;

endpackage

// ----- rtl/shp3_stream_if.sv -----
// ----------------------------------------------------------------------------
// shp3_in_if / shp3_out_if
// Valid/ready channels carrying input bytes and filtered result bytes.
// ----------------------------------------------------------------------------
interface shp3_in_if;
  import shp3_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                frame_start;

  modport source (output valid, output sample, output frame_start, input ready);
  modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

interface shp3_out_if;
  import shp3_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] pixel_value;
  logic [ROW_W-1:0]    out_row;
  logic [IDX_W-1:0]    out_byte_index;
  logic                end_of_run;
  logic                end_of_frame;

  modport source (output valid, output pixel_value, output out_row,
                  output out_byte_index, output end_of_run, output end_of_frame,
                  input ready);
  modport sink   (input valid, input pixel_value, input out_row,
                  input out_byte_index, input end_of_run, input end_of_frame,
                  output ready);
endinterface

// ----- rtl/shp3_ram.sv -----
// ----------------------------------------------------------------------------
// shp3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module shp3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/shp3_front.sv -----
// ----------------------------------------------------------------------------
// shp3_front
// Position tracking, line stores and kernel arithmetic; pushes one entry per
// byte of rows one and later into the result queue.
// ----------------------------------------------------------------------------
module shp3_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  shp3_pkg::cfg_t             cfg_i,
  shp3_in_if.sink                    in_i,
  input  logic [shp3_pkg::QCNT_W-1:0] q_count_i,
  output logic                       push_o,
  output shp3_pkg::item_t            item_o
);
  import shp3_pkg::*;

  logic [ROW_W-1:0] row_q, row_d;
  logic [IDX_W-1:0] byte_q, byte_d;

  logic                s1_valid_q;
  logic                s1_emit_q;
  logic                s1_interior_q;
  logic                s1_last_q;
  logic                s1_eof_q;
  logic [ROW_W-1:0]    s1_row_q;
  logic [IDX_W-1:0]    s1_byte_q;
  logic [SAMPLE_W-1:0] s1_sample_q;

  logic [SAMPLE_W-1:0] dl_q [MAX_CHANNELS];

  logic                accept;
  logic                restart;
  logic [ROW_W-1:0]    r;
  logic [IDX_W-1:0]    b;
  logic [LEN_W-1:0]    b_ext;
  logic [LEN_W-1:0]    c_ext;
  logic [LEN_W-1:0]    b_next;
  logic [LEN_W-1:0]    right_addr;
  logic [HEIGHT_W-1:0] r_next;
  logic                last_row;
  logic                interior;
  logic                eof;

  logic [SAMPLE_W-1:0] centre, right_px, up_px, left_px;
  logic [CHAN_W-1:0]   c_m1;
  logic [SUM_W-1:0]    five_c;
  logic [SUM_W-1:0]    sum;
  logic [SAMPLE_W-1:0] sat;

  assign in_i.ready = (CREDIT_W'(q_count_i) + CREDIT_W'(s1_valid_q)) < CREDIT_W'(QUEUE_DEPTH);
  assign accept     = in_i.valid & in_i.ready;

  always_comb begin
    restart = in_i.frame_start
            | ({1'b0, byte_q} >= cfg_i.len)
            | ({1'b0, row_q} >= cfg_i.height);
    r          = restart ? '0 : row_q;
    b          = restart ? '0 : byte_q;
    b_ext      = {1'b0, b};
    c_ext      = LEN_W'(cfg_i.chans);
    b_next     = b_ext + LEN_W'(1);
    right_addr = b_ext + c_ext;
    r_next     = {1'b0, r} + HEIGHT_W'(1);
    last_row   = ({1'b0, r} == (cfg_i.height - HEIGHT_W'(1)));
    interior   = (r > ROW_W'(1)) && (b_ext >= c_ext) && (b_ext < (cfg_i.len - c_ext));
    eof        = last_row && (b_ext == (cfg_i.len - LEN_W'(1)));
    if (b_next >= cfg_i.len) begin
      byte_d = '0;
      row_d  = (r_next >= cfg_i.height) ? '0 : r_next[ROW_W-1:0];
    end else begin
      byte_d = b_next[IDX_W-1:0];
      row_d  = r;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      byte_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        row_q  <= row_d;
        byte_q <= byte_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_emit_q     <= (r != '0);
      s1_interior_q <= interior;
      s1_last_q     <= last_row;
      s1_eof_q      <= eof;
      s1_row_q      <= r;
      s1_byte_q     <= b;
      s1_sample_q   <= in_i.sample;
    end
    if (s1_valid_q) begin
      dl_q[0] <= centre;
      for (int i = 1; i < MAX_CHANNELS; i++) begin
        dl_q[i] <= dl_q[i-1];
      end
    end
  end

  shp3_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_recent_ctr (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (b[ADDR_W-1:0]),
    .wdata_i (in_i.sample),
    .raddr_i (b[ADDR_W-1:0]),
    .rdata_o (centre)
  );

  shp3_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_recent_rgt (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (b[ADDR_W-1:0]),
    .wdata_i (in_i.sample),
    .raddr_i (right_addr[ADDR_W-1:0]),
    .rdata_o (right_px)
  );

  shp3_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_older (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_byte_q[ADDR_W-1:0]),
    .wdata_i (centre),
    .raddr_i (b[ADDR_W-1:0]),
    .rdata_o (up_px)
  );

  always_comb begin
    c_m1    = cfg_i.chans - CHAN_W'(1);
    left_px = dl_q[c_m1[CSEL_W-1:0]];
    five_c  = SUM_W'(centre) * SUM_W'(KERNEL_CENTRE);
    sum     = five_c - SUM_W'(left_px) - SUM_W'(right_px) - SUM_W'(up_px)
            - SUM_W'(s1_sample_q);
    if (sum[SUM_W-1]) begin
      sat = '0;
    end else if (sum[SUM_W-2:SAMPLE_W] != '0) begin
      sat = '1;
    end else begin
      sat = sum[SAMPLE_W-1:0];
    end
  end

  assign push_o          = s1_valid_q & s1_emit_q;
  assign item_o.value    = s1_interior_q ? sat : '0;
  assign item_o.row      = s1_row_q;
  assign item_o.idx      = s1_byte_q;
  assign item_o.last_row = s1_last_q;
  assign item_o.eof      = s1_eof_q;

endmodule

// ----- rtl/shp3_queue.sv -----
// ----------------------------------------------------------------------------
// shp3_queue
// Small FIFO decoupling the filter front from the result sequencer.
// ----------------------------------------------------------------------------
module shp3_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  shp3_pkg::item_t             item_i,
  input  logic                        pop_i,
  output shp3_pkg::item_t             head_o,
  output logic [shp3_pkg::QCNT_W-1:0] count_o
);
  import shp3_pkg::*;

  item_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= item_i;
    end
  end

  assign head_o  = entry_q[rptr_q];
  assign count_o = count_q;

endmodule

// ----- rtl/shp3_back.sv -----
// ----------------------------------------------------------------------------
// shp3_back
// Result sequencer: expands each queued entry into one or two output bytes
// and holds them in the output register.
// ----------------------------------------------------------------------------
module shp3_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  shp3_pkg::item_t             head_i,
  input  logic [shp3_pkg::QCNT_W-1:0] count_i,
  output logic                        pop_o,
  shp3_out_if.source                  out_o
);
  import shp3_pkg::*;

  logic                ov_q, ov_d;
  logic                phase_q, phase_d;
  logic                load;
  logic                avail;
  logic [SAMPLE_W-1:0] val_q, val_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                eor_q, eor_d;
  logic                eof_q, eof_d;

  assign avail = (count_i != '0);
  assign load  = ~ov_q | out_o.ready;

  always_comb begin
    ov_d    = ov_q;
    phase_d = phase_q;
    pop_o   = 1'b0;
    val_d   = val_q;
    row_d   = row_q;
    idx_d   = idx_q;
    eor_d   = eor_q;
    eof_d   = eof_q;
    if (load) begin
      ov_d = avail;
      if (avail) begin
        idx_d = head_i.idx;
        if (!phase_q) begin
          val_d   = head_i.value;
          row_d   = head_i.row - ROW_W'(1);
          eor_d   = ~head_i.last_row;
          eof_d   = 1'b0;
          phase_d = head_i.last_row;
          pop_o   = ~head_i.last_row;
        end else begin
          val_d   = '0;
          row_d   = head_i.row;
          eor_d   = 1'b1;
          eof_d   = head_i.eof;
          phase_d = 1'b0;
          pop_o   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q    <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      ov_q    <= ov_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    row_q <= row_d;
    idx_q <= idx_d;
    eor_q <= eor_d;
    eof_q <= eof_d;
  end

  assign out_o.valid          = ov_q;
  assign out_o.pixel_value    = val_q;
  assign out_o.out_row        = row_q;
  assign out_o.out_byte_index = idx_q;
  assign out_o.end_of_run     = eor_q;
  assign out_o.end_of_frame   = eof_q;

endmodule

// ----- rtl/sharpen_3x3_line_buffer_filter_core.sv -----
// ----------------------------------------------------------------------------
// sharpen_3x3_line_buffer_filter_core
// 3x3 cross-kernel sharpening of an interleaved-channel raster byte stream.
// ----------------------------------------------------------------------------
// in_i carries one channel byte per transaction in raster order; frame_start
// marks byte zero of row zero. Each byte of row r >= 1 yields the filtered
// byte of row r-1 at the same byte position on out_o; bytes of the last row
// also yield the zero bottom-border byte, with end_of_run on the second one.
// Row zero yields nothing. Border rows and columns give zero.
// APB registers: 0x0 frame_width, 0x4 frame_height, 0x8 channel_count; write
// them only while the stream is idle. Out-of-range values are clamped.
// The first result of a byte passes the stage-one registers, the queue and
// the output register. Throughput: one byte per cycle while out_o is ready;
// on the last row each entry gives two output bytes and out_o sets the rate.
// When out_o stalls, a 4-entry queue absorbs results and in_i.ready drops once
// the queued entries plus the one in-flight stage reach the queue depth.
// Reset restores register defaults (640 x 480, 3 channels) and zeroes the
// position counters; the line stores are not cleared.
// ----------------------------------------------------------------------------
module sharpen_3x3_line_buffer_filter_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  shp3_in_if.sink                           in_i,
  shp3_out_if.source                        out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [shp3_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [shp3_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [shp3_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import shp3_pkg::*;

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [CHAN_W-1:0]   chans_q;
  logic                wr_en;
  cfg_reg_e            reg_sel;
  cfg_t                cfg;
  logic [WIDTH_W-1:0]  w_cl;
  logic [HEIGHT_W-1:0] h_cl;
  logic [CHAN_W-1:0]   c_cl;
  logic [WIDTH_W+CHAN_W-1:0] len_full;

  logic              push;
  logic              pop;
  item_t             item;
  item_t             head;
  logic [QCNT_W-1:0] q_count;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
      chans_q  <= CHAN_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_FRAME_WIDTH:   width_q  <= pwdata[WIDTH_W-1:0];
        REG_FRAME_HEIGHT:  height_q <= pwdata[HEIGHT_W-1:0];
        REG_CHANNEL_COUNT: chans_q  <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FRAME_WIDTH:   prdata = APB_DATA_W'(width_q);
      REG_FRAME_HEIGHT:  prdata = APB_DATA_W'(height_q);
      REG_CHANNEL_COUNT: prdata = APB_DATA_W'(chans_q);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    if (width_q < WIDTH_W'(3)) begin
      w_cl = WIDTH_W'(3);
    end else if (width_q > WIDTH_W'(MAX_WIDTH)) begin
      w_cl = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_cl = width_q;
    end
    if (height_q < HEIGHT_W'(3)) begin
      h_cl = HEIGHT_W'(3);
    end else if (height_q > HEIGHT_W'(MAX_HEIGHT)) begin
      h_cl = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_cl = height_q;
    end
    if (chans_q < CHAN_W'(1)) begin
      c_cl = CHAN_W'(1);
    end else if (chans_q > CHAN_W'(MAX_CHANNELS)) begin
      c_cl = CHAN_W'(MAX_CHANNELS);
    end else begin
      c_cl = chans_q;
    end
    len_full   = (WIDTH_W+CHAN_W)'(w_cl) * (WIDTH_W+CHAN_W)'(c_cl);
    cfg.width  = w_cl;
    cfg.height = h_cl;
    cfg.chans  = c_cl;
    cfg.len    = len_full[LEN_W-1:0];
  end

  shp3_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_i      (in_i),
    .q_count_i (q_count),
    .push_o    (push),
    .item_o    (item)
  );

  shp3_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (q_count)
  );

  shp3_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .count_i (q_count),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
